// File: rtl/core/jsv_pkg.sv
// jsv_pkg: types and constants of the JSON string validator.
// Depends on nothing; imported by json_string_validator_unit, jsv_checker and the bench.
package jsv_pkg;

    localparam int unsigned CountWidth = 32;
    localparam int unsigned ByteWidth  = 8;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STR     = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX     = 3'd3,
        MODE_UTF8    = 3'd4,
        MODE_PAIR_BS = 3'd5,
        MODE_PAIR_U  = 3'd6
    } scan_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_IN   = 4'd1,
        ST_DONE = 4'd2,
        ST_CTRL = 4'd3,
        ST_ESC  = 4'd4,
        ST_HEX  = 4'd5,
        ST_LOW  = 4'd6,
        ST_HIGH = 4'd7,
        ST_UTF8 = 4'd8,
        ST_LONG = 4'd9
    } status_t;

    // surrogate class of the current \u escape
    typedef enum logic [1:0] {
        SUR_NONE = 2'd0,
        SUR_D    = 2'd1,
        SUR_HIGH = 2'd2,
        SUR_LOW  = 2'd3
    } sur_class_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CONT_LO  = 8'h80;
    localparam logic [7:0] CONT_HI  = 8'hBF;

    localparam logic [CountWidth-1:0] MAX_BYTES_RST = '1;

endpackage

// File: rtl/core/json_string_validator_unit.sv
// json_string_validator_unit: JSON string literal and UTF-8 checker, one byte a beat.
// Depends on jsv_pkg.
//
//  channel | direction | ports                                | beat
//  s_      | in        | s_valid s_ready s_text_byte          | one text byte
//  m_      | out       | m_valid m_ready m_status m_byte_count | one result
//  cfg_    | in        | cfg_wr_en cfg_wr_data                | max_string_bytes
//
// One byte per cycle while no stall on m_ holds the flow; a byte accepted on s_
// passes the input register, then the scan logic into the result register, which drives m_valid.
// aresetn is synchronous, active low; it clears the scan state and sets the
// length limit to all ones. A stall on m_ holds the result register; the input
// register still takes one more byte if it was empty, then s_ready drops.
module json_string_validator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_text_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output jsv_pkg::status_t                  m_status,
    output logic [jsv_pkg::CountWidth-1:0]    m_byte_count,
    input  logic                              cfg_wr_en,
    input  logic [jsv_pkg::CountWidth-1:0]    cfg_wr_data
);
    import jsv_pkg::*;

    logic                   in_vld_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_vld_reg;
    status_t                out_status_reg, out_status_next;
    logic [CountWidth-1:0]  out_count_reg, out_count_next;
    logic [CountWidth-1:0]  max_bytes_reg;

    scan_mode_t             mode_reg, mode_next;
    logic [2:0]             hex_left_reg, hex_left_next;
    logic [1:0]             cont_left_reg, cont_left_next;
    logic [7:0]             cont_lo_reg, cont_lo_next;
    logic [7:0]             cont_hi_reg, cont_hi_next;
    logic                   hs_seen_reg, hs_seen_next;
    sur_class_t             sur_reg, sur_next;
    logic [CountWidth-1:0]  bytes_reg, bytes_next;

    logic advance;
    logic [7:0] b;
    logic is_hex;

    assign advance      = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready      = !in_vld_reg || advance;
    assign m_valid      = out_vld_reg;
    assign m_status     = out_status_reg;
    assign m_byte_count = out_count_reg;
    assign b            = in_byte_reg;
    assign is_hex       = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};

    always_comb begin
        status_t st;
        logic [2:0] hl_dec;
        logic [1:0] cl_dec;
        logic ok;
        st             = ST_IN;
        hl_dec         = hex_left_reg - 3'd1;
        cl_dec         = cont_left_reg - 2'd1;
        ok             = 1'b0;
        mode_next      = mode_reg;
        hex_left_next  = hex_left_reg;
        cont_left_next = cont_left_reg;
        cont_lo_next   = cont_lo_reg;
        cont_hi_next   = cont_hi_reg;
        hs_seen_next   = hs_seen_reg;
        sur_next       = sur_reg;
        bytes_next     = bytes_reg;
        out_count_next = '0;

        if (mode_reg == MODE_IDLE) begin
            st = (b == CH_QUOTE) ? ST_IN : ST_IDLE;
        end else if (bytes_reg >= max_bytes_reg) begin
            st = ST_LONG;
        end else begin
            bytes_next = bytes_reg + 1'b1;
            case (mode_reg)
                MODE_STR: begin
                    if (b == CH_QUOTE) begin
                        st = ST_DONE;
                    end else if (b == CH_BSL) begin
                        mode_next = MODE_ESC;
                    end else if (b < 8'h20) begin
                        st = ST_CTRL;
                    end else if (b >= 8'h80) begin
                        mode_next    = MODE_UTF8;
                        cont_lo_next = CONT_LO;
                        cont_hi_next = CONT_HI;
                        if (b inside {[8'hC0:8'hDF]}) begin
                            cont_left_next = 2'd1;
                        end else if (b == 8'hE0) begin
                            cont_left_next = 2'd2;
                            cont_lo_next   = 8'hA0;
                        end else if (b == 8'hED) begin
                            cont_left_next = 2'd2;
                            cont_hi_next   = 8'h9F;
                        end else if (b inside {[8'hE1:8'hEF]}) begin
                            cont_left_next = 2'd2;
                        end else if (b == 8'hF0) begin
                            cont_left_next = 2'd3;
                            cont_lo_next   = 8'h90;
                        end else if (b inside {[8'hF1:8'hF3]}) begin
                            cont_left_next = 2'd3;
                        end else if (b == 8'hF4) begin
                            cont_left_next = 2'd3;
                            cont_hi_next   = 8'h8F;
                        end else begin
                            st = ST_UTF8;
                        end
                    end
                end
                MODE_ESC: begin
                    if (b inside {8'h62, 8'h74, 8'h6E, 8'h66, 8'h72, 8'h22, 8'h2F, 8'h5C}) begin
                        mode_next = MODE_STR;
                    end else if (b == CH_U) begin
                        mode_next     = MODE_HEX;
                        hex_left_next = 3'd4;
                        sur_next      = SUR_NONE;
                        hs_seen_next  = 1'b0;
                    end else begin
                        st = ST_ESC;
                    end
                end
                MODE_UTF8: begin
                    if (b < cont_lo_reg || b > cont_hi_reg) begin
                        st = ST_UTF8;
                    end else begin
                        cont_lo_next   = CONT_LO;
                        cont_hi_next   = CONT_HI;
                        cont_left_next = cl_dec;
                        if (cl_dec == 2'd0) mode_next = MODE_STR;
                    end
                end
                MODE_PAIR_BS: begin
                    if (b != CH_BSL) st = ST_HIGH;
                    else mode_next = MODE_PAIR_U;
                end
                MODE_PAIR_U: begin
                    if (b != CH_U) begin
                        st = ST_HIGH;
                    end else begin
                        mode_next     = MODE_HEX;
                        hex_left_next = 3'd4;
                        hs_seen_next  = 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (hs_seen_reg) begin
                        if (hex_left_reg == 3'd4) ok = (b == 8'h44) || (b == 8'h64);
                        else if (hex_left_reg == 3'd3)
                            ok = b inside {[8'h43:8'h46], [8'h63:8'h66]};
                        else ok = is_hex;
                        if (!ok) st = ST_HIGH;
                    end else if (!is_hex) begin
                        st = ST_HEX;
                    end else if (hex_left_reg == 3'd4) begin
                        sur_next = ((b == 8'h44) || (b == 8'h64)) ? SUR_D : SUR_NONE;
                    end else if (hex_left_reg == 3'd3 && sur_reg == SUR_D) begin
                        if (b inside {8'h38, 8'h39, 8'h41, 8'h42, 8'h61, 8'h62})
                            sur_next = SUR_HIGH;
                        else if (b > 8'h39)
                            sur_next = SUR_LOW;
                        else
                            sur_next = SUR_NONE;
                    end
                    if (st == ST_IN) begin
                        hex_left_next = hl_dec;
                        if (hl_dec == 3'd0) begin
                            if (hs_seen_reg) begin
                                hs_seen_next = 1'b0;
                                mode_next    = MODE_STR;
                            end else if (sur_next == SUR_LOW) begin
                                st = ST_LOW;
                            end else begin
                                mode_next = (sur_next == SUR_HIGH) ? MODE_PAIR_BS : MODE_STR;
                                sur_next  = SUR_NONE;
                            end
                        end
                    end
                end
                default: st = ST_ESC;
            endcase
            if (st == ST_DONE) out_count_next = bytes_next;
        end

        if (st != ST_IN) begin
            mode_next      = MODE_IDLE;
            hex_left_next  = '0;
            cont_left_next = '0;
            cont_lo_next   = CONT_LO;
            cont_hi_next   = CONT_HI;
            hs_seen_next   = 1'b0;
            sur_next       = SUR_NONE;
            bytes_next     = '0;
        end else if (mode_reg == MODE_IDLE) begin
            mode_next = MODE_STR;
        end
        out_status_next = st;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            max_bytes_reg <= MAX_BYTES_RST;
            mode_reg      <= MODE_IDLE;
            hex_left_reg  <= '0;
            cont_left_reg <= '0;
            cont_lo_reg   <= CONT_LO;
            cont_hi_reg   <= CONT_HI;
            hs_seen_reg   <= 1'b0;
            sur_reg       <= SUR_NONE;
            bytes_reg     <= '0;
        end else begin
            if (cfg_wr_en) max_bytes_reg <= cfg_wr_data;
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg   <= 1'b1;
                mode_reg      <= mode_next;
                hex_left_reg  <= hex_left_next;
                cont_left_reg <= cont_left_next;
                cont_lo_reg   <= cont_lo_next;
                cont_hi_reg   <= cont_hi_next;
                hs_seen_reg   <= hs_seen_next;
                sur_reg       <= sur_next;
                bytes_reg     <= bytes_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_byte_reg <= s_text_byte;
        if (advance) begin
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule

// File: rtl/core/jsv_checker.sv
// jsv_checker: port-level assertions for json_string_validator_unit, with its bind.
// Depends on jsv_pkg.
module jsv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input jsv_pkg::status_t               m_status,
    input logic [jsv_pkg::CountWidth-1:0] m_byte_count
);
    import jsv_pkg::*;

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_LONG))
        else $error("status code out of range");

    a_count_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DONE) |-> (m_byte_count == '0))
        else $error("byte count set on a beat that is not done");

    a_done_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_DONE) |-> (m_byte_count != '0))
        else $error("done beat without the closing quote counted");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_byte_count)))
        else $error("result beat changed while stalled");

endmodule

bind json_string_validator_unit jsv_checker u_jsv_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_byte_count (m_byte_count)
);

// File: tb/tb_json_string_validator_unit.sv
`timescale 1ns / 100ps
// tb_json_string_validator_unit: self-checking bench for json_string_validator_unit.
// Holds a byte-level predictor of the string checker and a verdict scoreboard
// class; depends on jsv_pkg and the DUT only.
module tb_json_string_validator_unit;
    import jsv_pkg::*;

    localparam int unsigned CycleLimit = 200000;

    typedef struct packed {
        status_t                 status;
        logic [CountWidth-1:0]   count;
    } verdict_t;

    // Tracks the scan state of the text stream and the verdicts still owed.
    class jsv_verdict_tracker;
        logic [CountWidth-1:0] limit;
        scan_mode_t            mode;
        logic [2:0]            hex_left;
        logic [1:0]            cont_left;
        logic [7:0]            cont_lo;
        logic [7:0]            cont_hi;
        logic                  pair_pending;
        sur_class_t            sur;
        logic [CountWidth-1:0] str_bytes;
        verdict_t              verdicts_due[$];
        int                    errors;
        int                    checked;
        int                    scanned;
        int                    sent;
        int                    hits[10];

        function new();
            limit = MAX_BYTES_RST;
            errors = 0;
            checked = 0;
            scanned = 0;
            sent = 0;
            foreach (hits[i]) hits[i] = 0;
            clear_string();
        endfunction

        function void set_limit(logic [CountWidth-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void clear_string();
            mode = MODE_IDLE;
            hex_left = '0;
            cont_left = '0;
            cont_lo = CONT_LO;
            cont_hi = CONT_HI;
            pair_pending = 1'b0;
            sur = SUR_NONE;
            str_bytes = '0;
        endfunction

        function bit is_hex(logic [7:0] b);
            return b inside {["0":"9"], ["A":"F"], ["a":"f"]};
        endfunction

        function void open_sequence(logic [1:0] left, logic [7:0] lo, logic [7:0] hi);
            mode = MODE_UTF8;
            cont_left = left;
            cont_lo = lo;
            cont_hi = hi;
        endfunction

        // status of one byte inside a string, count already taken
        function status_t scan_byte(logic [7:0] b);
            logic ok;
            case (mode)
                MODE_STR: begin
                    if (b == CH_QUOTE) return ST_DONE;
                    if (b == CH_BSL) begin
                        mode = MODE_ESC;
                        return ST_IN;
                    end
                    if (b < 8'h20) return ST_CTRL;
                    if (b < 8'h80) return ST_IN;
                    if (b inside {[8'hC0:8'hDF]}) open_sequence(2'd1, 8'h80, 8'hBF);
                    else if (b == 8'hE0) open_sequence(2'd2, 8'hA0, 8'hBF);
                    else if (b == 8'hED) open_sequence(2'd2, 8'h80, 8'h9F);
                    else if (b inside {[8'hE1:8'hEF]}) open_sequence(2'd2, 8'h80, 8'hBF);
                    else if (b == 8'hF0) open_sequence(2'd3, 8'h90, 8'hBF);
                    else if (b inside {[8'hF1:8'hF3]}) open_sequence(2'd3, 8'h80, 8'hBF);
                    else if (b == 8'hF4) open_sequence(2'd3, 8'h80, 8'h8F);
                    else return ST_UTF8;
                    return ST_IN;
                end
                MODE_ESC: begin
                    if (b inside {"b", "t", "n", "f", "r", CH_QUOTE, "/", CH_BSL}) begin
                        mode = MODE_STR;
                        return ST_IN;
                    end
                    if (b == CH_U) begin
                        mode = MODE_HEX;
                        hex_left = 3'd4;
                        sur = SUR_NONE;
                        pair_pending = 1'b0;
                        return ST_IN;
                    end
                    return ST_ESC;
                end
                MODE_UTF8: begin
                    if (b < cont_lo || b > cont_hi) return ST_UTF8;
                    cont_lo = CONT_LO;
                    cont_hi = CONT_HI;
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) mode = MODE_STR;
                    return ST_IN;
                end
                MODE_PAIR_BS: begin
                    if (b != CH_BSL) return ST_HIGH;
                    mode = MODE_PAIR_U;
                    return ST_IN;
                end
                MODE_PAIR_U: begin
                    if (b != CH_U) return ST_HIGH;
                    mode = MODE_HEX;
                    hex_left = 3'd4;
                    pair_pending = 1'b1;
                    return ST_IN;
                end
                MODE_HEX: begin
                    if (pair_pending) begin
                        if (hex_left == 3'd4) ok = b inside {"D", "d"};
                        else if (hex_left == 3'd3) ok = b inside {["C":"F"], ["c":"f"]};
                        else ok = is_hex(b);
                        if (!ok) return ST_HIGH;
                    end else begin
                        if (!is_hex(b)) return ST_HEX;
                        if (hex_left == 3'd4) begin
                            sur = (b inside {"D", "d"}) ? SUR_D : SUR_NONE;
                        end else if (hex_left == 3'd3 && sur == SUR_D) begin
                            if (b inside {"8", "9", "A", "B", "a", "b"}) sur = SUR_HIGH;
                            else if (b > "9") sur = SUR_LOW;
                            else sur = SUR_NONE;
                        end
                    end
                    hex_left = hex_left - 3'd1;
                    if (hex_left != 3'd0) return ST_IN;
                    if (pair_pending) begin
                        pair_pending = 1'b0;
                        mode = MODE_STR;
                        return ST_IN;
                    end
                    if (sur == SUR_LOW) return ST_LOW;
                    mode = (sur == SUR_HIGH) ? MODE_PAIR_BS : MODE_STR;
                    sur = SUR_NONE;
                    return ST_IN;
                end
                default: return ST_ESC;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            verdict_t v;
            v.count = '0;
            if (mode == MODE_IDLE) begin
                clear_string();
                if (b == CH_QUOTE) begin
                    mode = MODE_STR;
                    v.status = ST_IN;
                end else begin
                    v.status = ST_IDLE;
                end
            end else begin
                // length check comes before anything else
                if ({1'b0, str_bytes} + 33'd1 > {1'b0, limit}) begin
                    v.status = ST_LONG;
                end else begin
                    str_bytes = str_bytes + 1'b1;
                    v.status = scan_byte(b);
                end
                if (v.status == ST_DONE) v.count = str_bytes;
                if (v.status >= ST_DONE) clear_string();
            end
            sent++;
            if (v.status != ST_IDLE) scanned++;
            hits[int'(v.status)]++;
            verdicts_due.push_back(v);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(status_t st, logic [CountWidth-1:0] cnt);
            verdict_t v;
            if (verdicts_due.size() == 0) begin
                report($sformatf("result beat with nothing pending, status %0d", st));
                return;
            end
            v = verdicts_due.pop_front();
            checked++;
            if (st !== v.status)
                report($sformatf("status %0d, expected %0d", st, v.status));
            if (cnt !== v.count)
                report($sformatf("byte_count %0d, expected %0d", cnt, v.count));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_text_byte;
    logic                  m_valid;
    logic                  m_ready;
    status_t               m_status;
    logic [CountWidth-1:0] m_byte_count;
    logic                  cfg_wr_en;
    logic [CountWidth-1:0] cfg_wr_data;

    jsv_verdict_tracker tracker = new();
    logic [7:0]         text_q[$];
    bit                 steady = 1'b0;
    int                 cycles = 0;
    int                 limits_used = 1;

    json_string_validator_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_byte_count (m_byte_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycles, tracker.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_status, m_byte_count);
    end

    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 30) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.note_byte(b);
    endtask

    task automatic send_queued();
        while (text_q.size() != 0) send_byte(text_q.pop_front());
    endtask

    // hold off until every verdict is in, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CountWidth-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_limit(v);
        limits_used++;
    endtask

    function automatic logic [7:0] hex_digit();
        int unsigned n;
        n = $urandom_range(15);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [7:0] cont_byte(logic [7:0] lo, logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] escape_char();
        case ($urandom_range(7))
            0: return "b";
            1: return "t";
            2: return "n";
            3: return "f";
            4: return "r";
            5: return CH_QUOTE;
            6: return "/";
            default: return CH_BSL;
        endcase
    endfunction

    function automatic void add_token(ref logic [7:0] frag[$]);
        logic [7:0] c;
        case ($urandom_range(9))
            0, 1, 2: begin
                c = 8'($urandom_range(8'h7E, 8'h20));
                if (c == CH_QUOTE || c == CH_BSL) c = 8'h7F;
                frag.push_back(c);
            end
            3: begin
                frag.push_back(CH_BSL);
                frag.push_back(escape_char());
            end
            4: begin
                frag.push_back(CH_BSL);
                frag.push_back(CH_U);
                do c = hex_digit(); while (c inside {"D", "d"});
                frag.push_back(c);
                repeat (3) frag.push_back(hex_digit());
            end
            5: begin
                frag.push_back(CH_BSL);
                frag.push_back(CH_U);
                frag.push_back($urandom_range(1) ? "D" : "d");
                case ($urandom_range(2))
                    0: frag.push_back(8'("8" + $urandom_range(1)));
                    1: frag.push_back(8'("A" + $urandom_range(1)));
                    default: frag.push_back(8'("a" + $urandom_range(1)));
                endcase
                repeat (2) frag.push_back(hex_digit());
                frag.push_back(CH_BSL);
                frag.push_back(CH_U);
                frag.push_back($urandom_range(1) ? "D" : "d");
                frag.push_back(8'(($urandom_range(1) ? "C" : "c") + $urandom_range(3)));
                repeat (2) frag.push_back(hex_digit());
            end
            6: begin
                frag.push_back(8'($urandom_range(8'hDF, 8'hC0)));
                frag.push_back(cont_byte(CONT_LO, CONT_HI));
            end
            7: begin
                c = 8'($urandom_range(8'hEF, 8'hE0));
                frag.push_back(c);
                if (c == 8'hE0) frag.push_back(cont_byte(8'hA0, CONT_HI));
                else if (c == 8'hED) frag.push_back(cont_byte(CONT_LO, 8'h9F));
                else frag.push_back(cont_byte(CONT_LO, CONT_HI));
                frag.push_back(cont_byte(CONT_LO, CONT_HI));
            end
            8: begin
                c = 8'($urandom_range(8'hF4, 8'hF0));
                frag.push_back(c);
                if (c == 8'hF0) frag.push_back(cont_byte(8'h90, CONT_HI));
                else if (c == 8'hF4) frag.push_back(cont_byte(CONT_LO, 8'h8F));
                else frag.push_back(cont_byte(CONT_LO, CONT_HI));
                repeat (2) frag.push_back(cont_byte(CONT_LO, CONT_HI));
            end
            default: frag.push_back(8'h7F);
        endcase
    endfunction

    // mostly well-formed strings, some corrupted, some idle noise in between
    function automatic void build_string();
        logic [7:0] frag[$];
        int         n;
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(255)));
        frag.push_back(CH_QUOTE);
        n = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(6);
        repeat (n) add_token(frag);
        frag.push_back(CH_QUOTE);
        case ($urandom_range(7))
            0: frag[$urandom_range(frag.size() - 1, 1)] = 8'($urandom_range(255));
            1: frag.insert($urandom_range(frag.size() - 1, 1), 8'($urandom_range(255)));
            default: ;
        endcase
        text_q = {text_q, frag};
    endfunction

    task automatic run_phase(input int goal);
        int stop;
        stop = tracker.sent + goal;
        while (tracker.sent < stop) begin
            build_string();
            send_queued();
        end
    endtask

    initial begin
        string line;
        s_valid <= 1'b0;
        s_text_byte <= '0;
        m_ready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle extremes, control byte, quote inside UTF-8, bad escape,
        // 0x7F then lone low, bad hex, lone high, plain done
        text_q = {8'h00, 8'hFF,
                  CH_QUOTE, 8'h1F,
                  CH_QUOTE, 8'hC3, CH_QUOTE,
                  CH_QUOTE, CH_BSL, 8'h71,
                  CH_QUOTE, 8'h7F, CH_BSL, CH_U, 8'h44, 8'h43, 8'h30, 8'h30,
                  CH_QUOTE, CH_BSL, CH_U, 8'h67,
                  CH_QUOTE, CH_BSL, CH_U, 8'h64, 8'h62, 8'h66, 8'h66, 8'h78,
                  CH_QUOTE, 8'h61, CH_QUOTE};
        send_queued();

        run_phase(55);
        drain();
        run_phase(55);
        drain();
        write_limit(32'd1);
        run_phase(40);
        drain();
        write_limit(32'd0);
        run_phase(40);
        drain();
        write_limit(32'd3);
        run_phase(50);
        drain();
        write_limit(32'd12);
        run_phase(70);
        drain();
        steady = 1'b1;
        write_limit(32'($urandom_range(40, 4)));
        run_phase(80);
        drain();
        steady = 1'b0;
        write_limit(MAX_BYTES_RST);
        run_phase(110);
        drain();
        repeat (10) @(posedge aclk);

        $display("%0d text bytes sent, %0d inside strings, %0d verdicts checked, %0d limits",
                 tracker.sent, tracker.scanned, tracker.checked, limits_used);
        line = $sformatf("verdicts: idle %0d in %0d done %0d ctrl %0d esc %0d",
                         tracker.hits[0], tracker.hits[1], tracker.hits[2],
                         tracker.hits[3], tracker.hits[4]);
        line = {line, $sformatf(" hex %0d low %0d high %0d utf8 %0d long %0d",
                                tracker.hits[5], tracker.hits[6], tracker.hits[7],
                                tracker.hits[8], tracker.hits[9])};
        $display("%s", line);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/jsv_pkg.sv
rtl/core/json_string_validator_unit.sv
rtl/core/jsv_checker.sv
tb/tb_json_string_validator_unit.sv
